// File: hw/rtl/embossed_disabled_icon_defines.svh
// Assertion macros used by the top-level RTL of the embossed disabled icon block.
`ifndef EMBOSSED_DISABLED_ICON_DEFINES_SVH
`define EMBOSSED_DISABLED_ICON_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EDI_ASSERT_NOW(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("edi check failed");
`define EDI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edi check failed");
`else
`define EDI_ASSERT_NOW(lbl, clk, rst, cond)
`define EDI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/edi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package edi_pkg;

  localparam int EDI_MAX_WIDTH = 256;

  localparam logic [7:0]  PIX_MAX     = 8'hFF;
  // Division of the channel sum by 3 as a multiply by 683 / 2048; exact for sums up to 765.
  localparam logic [9:0]  GRAY_RECIP  = 10'd683;

  localparam logic [8:0]  WIDTH_RST   = 9'd16;
  localparam logic [8:0]  HEIGHT_RST  = 9'd16;
  localparam logic [23:0] BASE_RST    = 24'hFFFFFF;
  localparam logic [23:0] BUTTON_RST  = 24'hC0C0C0;
  localparam logic [23:0] FG_RST      = 24'h000000;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_BASE   = 3'd2,
    REG_BUTTON = 3'd3,
    REG_FG     = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAY,
    ST_TINT,
    ST_MIX,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    K_COMP,
    K_EDGE,
    K_EMPTY,
    K_BOTTOM,
    K_NONE
  } kind_t;

  typedef struct packed {
    logic take;
    logic gray;
    logic tint;
    logic mix;
  } edi_ctrl_t;

  function automatic logic [7:0] gray_of(input logic [31:0] px);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(px[23:16]) + 10'(px[15:8]) + 10'(px[7:0]);
    prod = 20'(sum) * 20'(GRAY_RECIP);
    return prod[18:11];
  endfunction

  // Per channel (hi*w + lo*(255-w)) >> 8 on packed RGB.
  function automatic logic [23:0] mix_rgb(input logic [7:0] w, input logic [23:0] hi,
                                          input logic [23:0] lo);
    logic [15:0] acc;
    logic [23:0] res;
    logic [7:0]  wi;
    wi  = PIX_MAX - w;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      acc = 16'(hi[8*c +: 8]) * 16'(w) + 16'(lo[8*c +: 8]) * 16'(wi);
      res[8*c +: 8] = acc[15:8];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/edi_row_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module edi_row_mem import edi_pkg::*; #(
  parameter int DEPTH = EDI_MAX_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [31:0]                        wdata,
  output logic      [31:0]                        rdata
);

  logic [31:0] mem [DEPTH];

  // Read-first: the old row entry comes out while the new pixel goes in.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/edi_shade.sv
`timescale 1ns / 1ps
`default_nettype none
module edi_shade import edi_pkg::*; (
  input  wire logic        clk,
  input  wire edi_ctrl_t   ctrl,
  input  wire logic [31:0] src,
  input  wire logic [31:0] above,
  input  wire logic        present,
  input  wire logic [23:0] base,
  input  wire logic [23:0] button,
  input  wire logic [23:0] fg,
  output logic      [31:0] comp,
  output logic      [23:0] shd_src,
  output logic      [23:0] shd_abv,
  output logic      [7:0]  abv_a
);

  logic [7:0]  v_src;
  logic [7:0]  v_abv;
  logic [7:0]  v_ul;
  logic [23:0] face;
  logic [31:0] ul_px;
  logic [23:0] ul_shd;
  logic [7:0]  ul_a;
  logic [7:0]  under_a;
  logic [23:0] under_rgb;
  logic [7:0]  src_a;

  assign src_a     = src[31:24];
  assign under_rgb = present ? ul_shd : button;
  assign under_a   = present ? ul_a : 8'h00;

  always_ff @(posedge clk) begin
    // The entry read for the last item is the up-left neighbor of this one. Its shadow
    // is worked out again here so that it follows the current colors.
    if (ctrl.take) begin
      ul_px <= above;
    end
    if (ctrl.gray) begin
      v_src <= gray_of(src);
      v_abv <= gray_of(above);
      v_ul  <= gray_of(ul_px);
      abv_a <= above[31:24];
      ul_a  <= ul_px[31:24];
    end
    if (ctrl.tint) begin
      face    <= mix_rgb(v_src, button, fg);
      shd_src <= mix_rgb(v_src, button, base);
      shd_abv <= mix_rgb(v_abv, button, base);
      ul_shd  <= mix_rgb(v_ul, button, base);
    end
    if (ctrl.mix) begin
      comp <= {(src_a > under_a) ? src_a : under_a, mix_rgb(src_a, face, under_rgb)};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/embossed_disabled_icon.sv
// Channel   Direction  Width  Contents
// s_*       in         32     source pixel ARGB
// m_*       out        56     out_x, out_y, out_pixel; tlast marks the last result of an item
// cfg_*     in         3/24   register index and write data
//
// One item at a time: the first result follows the row memory read and the gray, tint and blend
// stages, then one result per cycle while m_tready is high; an item gives one to four results.
// rst is synchronous; it resets the counters, state and configuration registers but does not clear the row memory.
// No pixel is taken while rst is high.
// A stall on m_tready holds the current result; no new pixel is taken until the last one leaves.
`timescale 1ns / 1ps
`default_nettype none
`include "embossed_disabled_icon_defines.svh"
module embossed_disabled_icon import edi_pkg::*; #(
  parameter int MAX_WIDTH = EDI_MAX_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] src_pixel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [55:0] m_tdata,   // [8:0] out_x, [17:9] out_y, [49:18] out_pixel, zeros
  output logic             m_tlast,   // last_of_run
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = ((CW > 9) ? CW : 9) + 1;
  localparam int XW   = ((CW + 1) > 9) ? (CW + 1) : 9;

  logic [8:0]  width_q;
  logic [8:0]  height_q;
  logic [23:0] base_q;
  logic [23:0] button_q;
  logic [23:0] fg_q;

  state_t state, state_next;
  kind_t  kind, kind_next, kind_after;

  logic [CW-1:0]   col;
  logic [7:0]      row;
  logic [CW-1:0]   x_q;
  logic [7:0]      y_q;
  logic [31:0]     src_q;
  logic            row_end_q;
  logic            last_row_q;
  logic            first_col_q;
  logic            top_q;

  logic [CMPW-1:0] w_ext;
  logic [CMPW-1:0] wm1;
  logic [7:0]      hm1;
  logic            row_end;
  logic            last_row;
  logic            in_acc;
  logic            out_acc;
  edi_ctrl_t       ctrl;

  logic [31:0] above;
  logic [31:0] comp;
  logic [23:0] shd_src;
  logic [23:0] shd_abv;
  logic [7:0]  abv_a;

  logic [XW-1:0] xs;
  logic [XW-1:0] x1;
  logic [8:0]    y9;
  logic [8:0]    y1;
  logic [8:0]    ox;
  logic [8:0]    oy;
  logic [31:0]   pix;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      base_q   <= BASE_RST;
      button_q <= BUTTON_RST;
      fg_q     <= FG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_q  <= cfg_data[8:0];
        REG_HEIGHT: height_q <= cfg_data[8:0];
        REG_BASE:   base_q   <= cfg_data;
        REG_BUTTON: button_q <= cfg_data;
        REG_FG:     fg_q     <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Effective last column and last row, with zero acting as one and large sizes clamped.
  assign w_ext = CMPW'(width_q);
  always_comb begin
    if (width_q == 9'd0) begin
      wm1 = '0;
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      wm1 = CMPW'(MAX_WIDTH - 1);
    end else begin
      wm1 = w_ext - CMPW'(1);
    end
    if (height_q == 9'd0) begin
      hm1 = 8'd0;
    end else if (height_q > 9'd256) begin
      hm1 = 8'd255;
    end else begin
      hm1 = 8'(height_q - 9'd1);
    end
  end

  assign row_end  = CMPW'(col) >= wm1;
  assign last_row = row >= hm1;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Result that follows the current one; K_NONE ends the item.
  always_comb begin
    unique case (kind)
      K_COMP: begin
        if (row_end_q) begin
          kind_after = K_EDGE;
        end else if (last_row_q) begin
          kind_after = first_col_q ? K_EMPTY : K_BOTTOM;
        end else begin
          kind_after = K_NONE;
        end
      end
      K_EDGE: begin
        if (last_row_q) begin
          kind_after = first_col_q ? K_EMPTY : K_BOTTOM;
        end else begin
          kind_after = K_NONE;
        end
      end
      K_EMPTY: kind_after = K_BOTTOM;
      default: kind_after = K_NONE;
    endcase
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          ctrl.take  = 1'b1;
          state_next = ST_GRAY;
        end
      end
      ST_GRAY: begin
        ctrl.gray  = 1'b1;
        state_next = ST_TINT;
      end
      ST_TINT: begin
        ctrl.tint  = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        ctrl.mix   = 1'b1;
        kind_next  = K_COMP;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          kind_next = kind_after;
          if (kind_after == K_NONE) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kind  <= K_NONE;
      col   <= '0;
      row   <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (in_acc) begin
        if (row_end) begin
          col <= '0;
          row <= last_row ? 8'd0 : row + 8'd1;
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_q       <= s_tdata;
      x_q         <= col;
      y_q         <= row;
      row_end_q   <= row_end;
      last_row_q  <= last_row;
      first_col_q <= (col == '0);
      top_q       <= (row == 8'd0);
    end
  end

  edi_row_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_row_mem (
    .clk   (clk),
    .en    (in_acc),
    .addr  (col),
    .wdata (s_tdata),
    .rdata (above)
  );

  edi_shade u_shade (
    .clk     (clk),
    .ctrl    (ctrl),
    .src     (src_q),
    .above   (above),
    .present (!first_col_q && !top_q),
    .base    (base_q),
    .button  (button_q),
    .fg      (fg_q),
    .comp    (comp),
    .shd_src (shd_src),
    .shd_abv (shd_abv),
    .abv_a   (abv_a)
  );

  assign xs = XW'(x_q);
  assign x1 = xs + XW'(1);
  assign y9 = {1'b0, y_q};
  assign y1 = y9 + 9'd1;

  always_comb begin
    unique case (kind)
      K_COMP: begin
        ox  = xs[8:0];
        oy  = y9;
        pix = comp;
      end
      K_EDGE: begin
        ox  = x1[8:0];
        oy  = y9;
        pix = top_q ? {8'h00, button_q} : {abv_a, shd_abv};
      end
      K_EMPTY: begin
        ox  = 9'd0;
        oy  = y1;
        pix = {8'h00, button_q};
      end
      default: begin
        ox  = x1[8:0];
        oy  = y1;
        pix = {src_q[31:24], shd_src};
      end
    endcase
  end

  assign m_tdata = {6'b0, pix, oy, ox};
  assign m_tlast = (kind_after == K_NONE);

  `EDI_ASSERT_NOW(a_sides_apart, clk, rst, !(s_tready && m_tvalid))
  `EDI_ASSERT_NEXT(a_no_early_result, clk, rst, in_acc, !s_tready && !m_tvalid)
  `EDI_ASSERT_NEXT(a_back_to_idle, clk, rst, out_acc && m_tlast, s_tready)
  `EDI_ASSERT_NOW(a_first_is_comp, clk, rst, !(state == ST_MIX) || (kind_next == K_COMP))

endmodule
`default_nettype wire
